// ===== sv/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types and constants of the utf-16 to utf-8 encoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam logic [15:0] HIGH_MIN    = 16'hD800;
  localparam logic [15:0] HIGH_MAX    = 16'hDBFF;
  localparam logic [15:0] LOW_MIN     = 16'hDC00;
  localparam logic [15:0] LOW_MAX     = 16'hDFFF;
  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [7:0]  LEAD2       = 8'hC0;
  localparam logic [7:0]  LEAD3       = 8'hE0;
  localparam logic [7:0]  LEAD4       = 8'hF0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;
  localparam logic [2:0]  MAX_BYTES   = 3'd4;

  // bytes[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            fin;
  } enc_t;

endpackage

// ===== sv/u16u8_dec.sv =====
// ----------------------------------------------------------------------------
// u16u8_dec
// input register, surrogate pairing and utf-8 byte formation
// ----------------------------------------------------------------------------
module u16u8_dec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  input  logic                 in_tlast,
  output logic                 enc_valid,
  input  logic                 enc_ready,
  output u16u8_pkg::enc_t      enc
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] unit_r;
  logic        fin_r;
  logic        pend_r, pend_nxt;
  logic [9:0]  payload_r, payload_nxt;

  logic        is_high, is_low, hold, adv;
  logic [20:0] cp;
  logic [2:0]  n;

  always_comb begin
    is_high = (unit_r >= u16u8_pkg::HIGH_MIN) && (unit_r <= u16u8_pkg::HIGH_MAX);
    is_low  = (unit_r >= u16u8_pkg::LOW_MIN) && (unit_r <= u16u8_pkg::LOW_MAX);
    hold    = 1'b0;
    if (pend_r) begin
      if (is_low) begin
        cp = u16u8_pkg::SUPP_BASE + {1'b0, payload_r, unit_r[9:0]};
      end else begin
        cp = u16u8_pkg::REPLACEMENT;
      end
    end else if (is_high) begin
      cp   = u16u8_pkg::REPLACEMENT;
      hold = !fin_r;
    end else begin
      cp = {5'd0, unit_r};
    end

    if (hold) begin
      n = 3'd0;
    end else if (cp[20:7] == 14'd0) begin
      n = 3'd1;
    end else if (cp[20:11] == 10'd0) begin
      n = 3'd2;
    end else if (cp[20:16] == 5'd0) begin
      n = 3'd3;
    end else begin
      n = u16u8_pkg::MAX_BYTES;
    end

    enc.bytes = '0;
    case (n)
      3'd1: begin
        enc.bytes[0] = {1'b0, cp[6:0]};
      end
      3'd2: begin
        enc.bytes[0] = u16u8_pkg::LEAD2 | {3'd0, cp[10:6]};
        enc.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
      end
      3'd3: begin
        enc.bytes[0] = u16u8_pkg::LEAD3 | {4'd0, cp[15:12]};
        enc.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
        enc.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
      end
      3'd4: begin
        enc.bytes[0] = u16u8_pkg::LEAD4 | {5'd0, cp[20:18]};
        enc.bytes[1] = u16u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
        enc.bytes[2] = u16u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
        enc.bytes[3] = u16u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
      end
      default: begin
        enc.bytes = '0;
      end
    endcase
    enc.cnt = n;
    enc.fin = fin_r;

    enc_valid = s1_valid_r && (n != 3'd0);
    adv       = s1_valid_r && ((n == 3'd0) || enc_ready);
    in_tready = !s1_valid_r || adv;

    s1_valid_nxt = in_tvalid ? 1'b1 : (s1_valid_r && !adv);
    pend_nxt     = pend_r;
    payload_nxt  = payload_r;
    if (adv) begin
      pend_nxt    = hold;
      payload_nxt = hold ? unit_r[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r     <= 1'b0;
      payload_r  <= 10'd0;
    end else begin
      s1_valid_r <= in_tready ? s1_valid_nxt : s1_valid_r;
      pend_r     <= pend_nxt;
      payload_r  <= payload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      unit_r <= in_tdata;
      fin_r  <= in_tlast;
    end
  end

`ifndef SYNTHESIS
  a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && pend_r) |=> !pend_r)
    else $error("held high surrogate not released");
  a_final_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && fin_r) |=> !pend_r)
    else $error("surrogate held past end of string");
  a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && hold) |-> !enc_valid)
    else $error("held surrogate produced bytes");
`endif

endmodule

// ===== sv/u16u8_ser.sv =====
// ----------------------------------------------------------------------------
// u16u8_ser
// byte buffer and output register, one byte per cycle while out_tready is high
// ----------------------------------------------------------------------------
module u16u8_ser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 enc_valid,
  output logic                 enc_ready,
  input  u16u8_pkg::enc_t      enc,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic [0:0]           out_tuser
);

  logic [3:0][7:0] byte_r, byte_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            fin_r, fin_nxt;
  logic            take;

  always_comb begin
    out_tvalid   = (cnt_r != 3'd0);
    out_tdata    = byte_r[0];
    out_tlast    = (cnt_r == 3'd1);
    out_tuser[0] = fin_r && (cnt_r == 3'd1);
    take         = out_tvalid && out_tready;
    enc_ready    = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);

    byte_nxt = byte_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    if (enc_valid && enc_ready) begin
      byte_nxt = enc.bytes;
      cnt_nxt  = enc.cnt;
      fin_nxt  = enc.fin;
    end else if (take) begin
      byte_nxt = {8'd0, byte_r[3], byte_r[2], byte_r[1]};
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    fin_r  <= fin_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= u16u8_pkg::MAX_BYTES)
    else $error("byte count out of range");
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_tlast) |=> (out_tvalid && (cnt_r == $past(cnt_r) - 3'd1)))
    else $error("bytes of an item lost");
  a_string_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("string end off the last byte");
`endif

endmodule

// ===== sv/utf16_to_utf8_encoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// utf-16 code units in, utf-8 bytes out, surrogate pairs joined
//
// channel  dir  tdata           tlast       tuser
// in_      in   code_unit[15:0] final_unit  -
// out_     out  utf8_byte[7:0]  run_end     string_end
//
// one output byte per cycle while out_tready is high; a unit yields
// 0 to 4 bytes, which the byte buffer holds and sends out in order
// a held high surrogate yields no byte and passes without a stall
// the next unit is taken while the bytes of the previous one drain
// reset is synchronous, active low, and clears the held surrogate
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // code_unit
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // utf8_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // string_end
);

  logic            enc_valid;
  logic            enc_ready;
  u16u8_pkg::enc_t enc;

  u16u8_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .enc_valid (enc_valid),
    .enc_ready (enc_ready),
    .enc       (enc)
  );

  u16u8_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .enc_valid  (enc_valid),
    .enc_ready  (enc_ready),
    .enc        (enc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
